### src/ray_simplex_clip_macros.svh
`ifndef RAY_SIMPLEX_CLIP_MACROS_SVH
`define RAY_SIMPLEX_CLIP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RSC_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int LANES     = 4;
	localparam int DIMS      = 3;
	localparam int N_MAT     = 9;
	localparam int N_WORDS   = 6;
	localparam int TOL_W     = 31;
	localparam int DIM_W     = 2;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int SUM_W     = 2 * COORD_W + 4;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 6;
	localparam int ADDR_LSB  = 3;
	localparam int IDX_W     = ADDR_W - ADDR_LSB;
	localparam longint RANGE_HI = 999;

	localparam logic [IDX_W-1:0] REG_TOL = 3'd6;
	localparam logic [IDX_W-1:0] REG_DIM = 3'd7;

	localparam logic [DIM_W-1:0] DIM_TET = 2'd3;

	typedef logic signed [COORD_W-1:0] fx_t;

	localparam fx_t FX_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		fx_t start_x;
		fx_t start_y;
		fx_t start_z;
		fx_t dir_x;
		fx_t dir_y;
		fx_t dir_z;
	} in_word_t;

	typedef struct packed {
		logic hit;
		fx_t  entry_b0;
		fx_t  entry_b1;
		fx_t  entry_b2;
		fx_t  entry_b3;
		fx_t  exit_b0;
		fx_t  exit_b1;
		fx_t  exit_b2;
		fx_t  exit_b3;
		fx_t  exit_param;
	} out_word_t;

	typedef struct packed {
		logic                   tet;
		logic [TOL_W-1:0]       tol;
		fx_t  [N_MAT-1:0]       mat;
		fx_t  [DIMS-1:0]        org;
	} cfg_t;

	typedef struct packed {
		logic             miss;
		logic [LANES-1:0] act;
		logic [LANES-1:0] neg;
		logic [LANES-1:0] pos;
		logic [LANES-1:0] qneg;
		fx_t  [LANES-1:0] v1;
		fx_t  [LANES-1:0] v2;
	} lane_t;

	function automatic fx_t sat_fx(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(FX_MAX);
		lo = SUM_W'(FX_MIN);
		if (x > hi) begin
			return FX_MAX;
		end else if (x < lo) begin
			return FX_MIN;
		end
		return x[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

### src/ray_simplex_clip.sv
// throughput: one ray per cycle, busy stays low
// the pipelined restoring divider, one quotient bit per stage over 32 + FRAC_BITS stages,
// is most of the pipeline; four stages before it and four after
// reset: asynchronous active-low arst_n clears pipeline valids and loads
// register defaults (matrix and origin zero, tolerance 1, tetrahedron)
`timescale 1ns / 1ps
`default_nettype none

`include "ray_simplex_clip_macros.svh"

module ray_simplex_clip import rsc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              start,
	output logic                   busy,
	input  wire in_word_t          ray,
	output logic                   done,
	output out_word_t              result
);

	localparam int NW  = COORD_W + FRAC_BITS;
	localparam int LAT = NW + 8;

	cfg_t                        cfg;
	logic                        acc;
	logic                        dim_wr;
	logic                        bary_vld;
	lane_t                       bary_lane;
	logic [LANES-1:0][NW-1:0]    bary_num;
	logic [LANES-1:0][COORD_W-1:0] bary_den;
	logic                        div_vld;
	logic [LANES-1:0][NW-1:0]    div_quo;
	lane_t                       div_sb;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign acc    = start & ~busy;
	assign dim_wr = psel & penable & pwrite & (paddr[ADDR_W-1:ADDR_LSB] == REG_DIM);

	rsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rsc_bary #(
		.FRAC_BITS (FRAC_BITS)
	) u_bary (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (acc),
		.ray    (ray),
		.cfg    (cfg),
		.vld_o  (bary_vld),
		.lane   (bary_lane),
		.num    (bary_num),
		.den    (bary_den)
	);

	rsc_div #(
		.NW   (NW),
		.DW   (COORD_W),
		.SB_W ($bits(lane_t))
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (bary_vld),
		.num_i  (bary_num),
		.den_i  (bary_den),
		.sb_i   (bary_lane),
		.vld_o  (div_vld),
		.quo_o  (div_quo),
		.sb_o   (div_sb)
	);

	rsc_clip #(
		.FRAC_BITS (FRAC_BITS)
	) u_clip (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (div_vld),
		.sb     (div_sb),
		.quo    (div_quo),
		.done   (done),
		.result (result)
	);

	`RSC_ASSERT(a_done_lat, done, $past(acc, LAT), "word out without a ray in")
	`RSC_ASSERT(a_miss_zero, done && !result.hit, result == '0, "miss word not cleared")
	`RSC_ASSERT(a_hit_param, done && result.hit, $signed(result.exit_param) > 0, "bad exit")
	`RSC_ASSERT_NEXT(a_dim_wr, dim_wr, cfg.tet == ($past(pwdata[DIM_W-1:0]) == DIM_TET), "dim lost")

endmodule

`default_nettype wire

### src/rsc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rsc_cfg import rsc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output cfg_t                   cfg
);

	logic [DATA_W-1:0] word_q [N_WORDS];
	logic [TOL_W-1:0]  tol_q;
	logic [DIM_W-1:0]  dim_q;
	logic [IDX_W-1:0]  idx;
	logic              wr;

	assign idx = paddr[ADDR_W-1:ADDR_LSB];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_WORDS; i++) begin
				word_q[i] <= '0;
			end
			tol_q <= TOL_W'(1);
			dim_q <= DIM_TET;
		end else if (wr) begin
			unique case (idx)
				REG_TOL: begin
					tol_q <= pwdata[TOL_W-1:0];
				end
				REG_DIM: begin
					dim_q <= pwdata[DIM_W-1:0];
				end
				default: begin
					word_q[idx] <= pwdata;
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TOL: begin
				prdata = DATA_W'(tol_q);
			end
			REG_DIM: begin
				prdata = DATA_W'(dim_q);
			end
			default: begin
				prdata = word_q[idx];
			end
		endcase
	end

	always_comb begin
		cfg.tet = (dim_q == DIM_TET);
		cfg.tol = tol_q;
		for (int e = 0; e < N_MAT; e++) begin
			if ((e % 2) == 1) begin
				cfg.mat[e] = word_q[e/2][63:32];
			end else begin
				cfg.mat[e] = word_q[e/2][31:0];
			end
		end
		cfg.org[0] = word_q[4][63:32];
		cfg.org[1] = word_q[5][31:0];
		cfg.org[2] = word_q[5][63:32];
	end

endmodule

`default_nettype wire

### src/rsc_bary.sv
`timescale 1ns / 1ps
`default_nettype none

module rsc_bary import rsc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_W
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              vld,
	input  wire in_word_t                          ray,
	input  wire cfg_t                              cfg,
	output logic                                   vld_o,
	output lane_t                                  lane,
	output logic [LANES-1:0][COORD_W+FRAC_BITS-1:0] num,
	output logic [LANES-1:0][COORD_W-1:0]          den
);

	localparam int NW = COORD_W + FRAC_BITS;
	localparam int XW = COORD_W + 2;

	logic                       vld_s1, vld_s2, vld_s3, vld_s4;
	fx_t                        vect_s1 [DIMS];
	fx_t                        dir_s1  [DIMS];
	logic signed [PROD_W-1:0]   p1_s2   [DIMS][DIMS];
	logic signed [PROD_W-1:0]   p2_s2   [DIMS][DIMS];
	fx_t                        v1_s3   [DIMS];
	fx_t                        v2_s3   [DIMS];
	lane_t                      lane_s4;
	logic [LANES-1:0][NW-1:0]   num_s4;
	logic [LANES-1:0][COORD_W-1:0] den_s4;

	fx_t                        start_c [DIMS];
	fx_t                        dir_c   [DIMS];
	logic signed [PROD_W-1:0]   p1_c    [DIMS][DIMS];
	logic signed [PROD_W-1:0]   p2_c    [DIMS][DIMS];
	lane_t                      lane_c;
	logic [LANES-1:0][NW-1:0]   num_c;
	logic [LANES-1:0][COORD_W-1:0] den_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// start minus origin
	assign start_c[0] = ray.start_x;
	assign start_c[1] = ray.start_y;
	assign start_c[2] = ray.start_z;
	assign dir_c[0]   = ray.dir_x;
	assign dir_c[1]   = ray.dir_y;
	assign dir_c[2]   = ray.dir_z;

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIMS; j++) begin
			vect_s1[j] <= sat_fx(SUM_W'(start_c[j]) - SUM_W'($signed(cfg.org[j])));
			dir_s1[j]  <= dir_c[j];
		end
	end

	// matrix products, floored
	always_comb begin
		fx_t a;
		for (int k = 0; k < DIMS; k++) begin
			for (int j = 0; j < DIMS; j++) begin
				if (cfg.tet) begin
					a = cfg.mat[k + 3*j];
				end else if (k < 2 && j < 2) begin
					a = cfg.mat[k + 2*j];
				end else begin
					a = '0;
				end
				p1_c[k][j] = (PROD_W'(a) * PROD_W'(vect_s1[j])) >>> FRAC_BITS;
				p2_c[k][j] = (PROD_W'(a) * PROD_W'(dir_s1[j])) >>> FRAC_BITS;
			end
		end
	end

	always_ff @(posedge clk) begin
		p1_s2 <= p1_c;
		p2_s2 <= p2_c;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIMS; k++) begin
			v1_s3[k] <= sat_fx(SUM_W'(p1_s2[k][0]) + SUM_W'(p1_s2[k][1])
				+ SUM_W'(p1_s2[k][2]));
			v2_s3[k] <= sat_fx(SUM_W'(p2_s2[k][0]) + SUM_W'(p2_s2[k][1])
				+ SUM_W'(p2_s2[k][2]));
		end
	end

	// last coordinate, facet classes, divider operands
	always_comb begin
		logic signed [SUM_W-1:0] s1;
		logic signed [SUM_W-1:0] s2;
		fx_t                     last1;
		fx_t                     last2;
		logic signed [XW-1:0]    tol_x;
		logic signed [XW-1:0]    v1x;
		logic signed [XW-1:0]    v2x;
		logic signed [XW-1:0]    nx;
		logic signed [XW-1:0]    mag_n;
		logic signed [XW-1:0]    mag_d;
		logic [LANES-1:0]        outside;
		s1 = SUM_W'(v1_s3[0]) + SUM_W'(v1_s3[1]) + SUM_W'(v1_s3[2]);
		s2 = SUM_W'(v2_s3[0]) + SUM_W'(v2_s3[1]) + SUM_W'(v2_s3[2]);
		last1 = sat_fx((SUM_W'(1) <<< FRAC_BITS) - s1);
		last2 = sat_fx(-s2);
		lane_c.v1[0] = v1_s3[0];
		lane_c.v1[1] = v1_s3[1];
		lane_c.v2[0] = v2_s3[0];
		lane_c.v2[1] = v2_s3[1];
		if (cfg.tet) begin
			lane_c.v1[2] = v1_s3[2];
			lane_c.v2[2] = v2_s3[2];
			lane_c.v1[3] = last1;
			lane_c.v2[3] = last2;
			lane_c.act   = '1;
		end else begin
			lane_c.v1[2] = last1;
			lane_c.v2[2] = last2;
			lane_c.v1[3] = '0;
			lane_c.v2[3] = '0;
			lane_c.act   = {1'b0, {(LANES-1){1'b1}}};
		end
		tol_x = XW'({1'b0, cfg.tol});
		for (int l = 0; l < LANES; l++) begin
			v1x = XW'($signed(lane_c.v1[l]));
			v2x = XW'($signed(lane_c.v2[l]));
			lane_c.neg[l] = (v2x < -tol_x);
			lane_c.pos[l] = (v2x > tol_x);
			outside[l]    = (v1x < -tol_x);
			nx            = -v1x;
			mag_n         = nx[XW-1] ? -nx : nx;
			mag_d         = v2x[XW-1] ? -v2x : v2x;
			lane_c.qneg[l] = nx[XW-1] ^ v2x[XW-1];
			num_c[l] = {mag_n[COORD_W-1:0], {FRAC_BITS{1'b0}}};
			den_c[l] = mag_d[COORD_W-1:0];
		end
		lane_c.miss = |(lane_c.act & ~lane_c.neg & ~lane_c.pos & outside);
	end

	always_ff @(posedge clk) begin
		lane_s4 <= lane_c;
		num_s4  <= num_c;
		den_s4  <= den_c;
	end

	assign vld_o = vld_s4;
	assign lane  = lane_s4;
	assign num   = num_s4;
	assign den   = den_s4;

endmodule

`default_nettype wire

### src/rsc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rsc_div import rsc_pkg::*; #(
	parameter int NW   = COORD_W + FRAC_W,
	parameter int DW   = COORD_W,
	parameter int SB_W = $bits(lane_t)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        vld_i,
	input  wire logic [LANES-1:0][NW-1:0]    num_i,
	input  wire logic [LANES-1:0][DW-1:0]    den_i,
	input  wire logic [SB_W-1:0]             sb_i,
	output logic                             vld_o,
	output logic      [LANES-1:0][NW-1:0]    quo_o,
	output logic      [SB_W-1:0]             sb_o
);

	// one quotient bit per stage, restoring
	logic [NW:0]                 vld_s;
	logic [LANES-1:0][NW-1:0]    nq_s  [NW+1];
	logic [LANES-1:0][DW-1:0]    rem_s [NW+1];
	logic [LANES-1:0][DW-1:0]    den_s [NW+1];
	logic [SB_W-1:0]             sb_s  [NW+1];

	assign vld_s[0] = vld_i;
	assign nq_s[0]  = num_i;
	assign rem_s[0] = '0;
	assign den_s[0] = den_i;
	assign sb_s[0]  = sb_i;

	for (genvar s = 0; s < NW; s++) begin : g_stage
		logic [LANES-1:0][NW-1:0] nq_c;
		logic [LANES-1:0][DW-1:0] rem_c;

		always_comb begin
			logic [DW:0] t;
			logic        ge;
			for (int l = 0; l < LANES; l++) begin
				t  = {rem_s[s][l], nq_s[s][l][NW-1]};
				ge = (t >= {1'b0, den_s[s][l]});
				if (ge) begin
					t = t - {1'b0, den_s[s][l]};
				end
				rem_c[l] = t[DW-1:0];
				nq_c[l]  = {nq_s[s][l][NW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else begin
				vld_s[s+1] <= vld_s[s];
			end
		end

		always_ff @(posedge clk) begin
			nq_s[s+1]  <= nq_c;
			rem_s[s+1] <= rem_c;
			den_s[s+1] <= den_s[s];
			sb_s[s+1]  <= sb_s[s];
		end
	end

	assign vld_o = vld_s[NW];
	assign quo_o = nq_s[NW];
	assign sb_o  = sb_s[NW];

endmodule

`default_nettype wire

### src/rsc_clip.sv
`timescale 1ns / 1ps
`default_nettype none

module rsc_clip import rsc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_W
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  vld,
	input  wire lane_t                                 sb,
	input  wire logic [LANES-1:0][COORD_W+FRAC_BITS-1:0] quo,
	output logic                                       done,
	output out_word_t                                  result
);

	localparam int     NW       = COORD_W + FRAC_BITS;
	localparam longint RMAX_RAW = RANGE_HI * (longint'(1) << FRAC_BITS);
	localparam fx_t    RMAX     = (RMAX_RAW > longint'(FX_MAX)) ? FX_MAX
		: RMAX_RAW[COORD_W-1:0];
	localparam logic [NW-1:0] NEG_LIM = NW'(1) << (COORD_W - 1);
	localparam logic [NW-1:0] POS_LIM = NW'(FX_MAX);

	logic                      vld_s1, vld_s2, vld_s3, done_s4;
	fx_t                       r_s1  [LANES];
	lane_t                     sb_s1, sb_s2, sb_s3;
	fx_t                       rlo_s2, rhi_s2, rhi_s3;
	logic                      hit_s3;
	logic signed [PROD_W-1:0]  pe_s3 [LANES];
	logic signed [PROD_W-1:0]  px_s3 [LANES];
	out_word_t                 res_s4;

	fx_t                       r_c   [LANES];
	fx_t                       rlo_c, rhi_c;
	logic signed [PROD_W-1:0]  pe_c  [LANES];
	logic signed [PROD_W-1:0]  px_c  [LANES];
	fx_t                       be_c  [LANES];
	fx_t                       bx_c  [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			done_s4 <= 1'b0;
		end else begin
			vld_s1  <= vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			done_s4 <= vld_s3;
		end
	end

	// signed, saturated quotients
	always_comb begin
		logic [NW-1:0] nq;
		for (int l = 0; l < LANES; l++) begin
			nq = NW'(0) - quo[l];
			if (sb.qneg[l]) begin
				r_c[l] = (quo[l] > NEG_LIM) ? FX_MIN : nq[COORD_W-1:0];
			end else begin
				r_c[l] = (quo[l] > POS_LIM) ? FX_MAX : quo[l][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		r_s1  <= r_c;
		sb_s1 <= sb;
	end

	// interval narrowing
	always_comb begin
		rlo_c = '0;
		rhi_c = RMAX;
		for (int l = 0; l < LANES; l++) begin
			if (sb_s1.act[l] && sb_s1.neg[l] && (r_s1[l] < rhi_c)) begin
				rhi_c = r_s1[l];
			end
			if (sb_s1.act[l] && sb_s1.pos[l] && (r_s1[l] > rlo_c)) begin
				rlo_c = r_s1[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		rlo_s2 <= rlo_c;
		rhi_s2 <= rhi_c;
		sb_s2  <= sb_s1;
	end

	// entry and exit offsets
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			pe_c[l] = (PROD_W'($signed(sb_s2.v2[l])) * PROD_W'(rlo_s2)) >>> FRAC_BITS;
			px_c[l] = (PROD_W'($signed(sb_s2.v2[l])) * PROD_W'(rhi_s2)) >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		hit_s3 <= !sb_s2.miss && (rhi_s2 > rlo_s2);
		pe_s3  <= pe_c;
		px_s3  <= px_c;
		rhi_s3 <= rhi_s2;
		sb_s3  <= sb_s2;
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (hit_s3 && sb_s3.act[l]) begin
				be_c[l] = sat_fx(SUM_W'($signed(sb_s3.v1[l])) + SUM_W'(pe_s3[l]));
				bx_c[l] = sat_fx(SUM_W'($signed(sb_s3.v1[l])) + SUM_W'(px_s3[l]));
			end else begin
				be_c[l] = '0;
				bx_c[l] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s4.hit        <= hit_s3;
		res_s4.entry_b0   <= be_c[0];
		res_s4.entry_b1   <= be_c[1];
		res_s4.entry_b2   <= be_c[2];
		res_s4.entry_b3   <= be_c[3];
		res_s4.exit_b0    <= bx_c[0];
		res_s4.exit_b1    <= bx_c[1];
		res_s4.exit_b2    <= bx_c[2];
		res_s4.exit_b3    <= bx_c[3];
		res_s4.exit_param <= hit_s3 ? rhi_s3 : '0;
	end

	assign done   = done_s4;
	assign result = res_s4;

endmodule

`default_nettype wire

### test/tb_ray_simplex_clip.sv
`timescale 1ns / 1ps

module tb_ray_simplex_clip;
	import rsc_pkg::*;

	localparam longint ONE = 64'sd65536;
	localparam int WATCHDOG = 4000;
	localparam int SETTLE = 80;

	class clip_scoreboard;
		logic [63:0] words [N_WORDS];
		logic [TOL_W-1:0] tol;
		logic [DIM_W-1:0] dim;
		out_word_t pending [$];
		int errors;
		int hits;
		int results;

		function new();
			foreach (words[i]) words[i] = '0;
			tol = 1;
			dim = DIM_TET;
			errors = 0;
			hits = 0;
			results = 0;
		endfunction

		function void set_reg(int idx, logic [63:0] v);
			if (idx < N_WORDS) words[idx] = v;
			else if (idx == int'(REG_TOL)) tol = v[TOL_W-1:0];
			else if (idx == int'(REG_DIM)) dim = v[DIM_W-1:0];
		endfunction

		function longint sx(logic [31:0] v);
			return longint'(signed'(v));
		endfunction

		function longint clamp(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function longint qmul(longint a, longint b);
			return (a * b) >>> FRAC_W;
		endfunction

		function longint coef(int e);
			logic [63:0] w;
			w = words[e / 2];
			return (e % 2) ? sx(w[63:32]) : sx(w[31:0]);
		endfunction

		function out_word_t clip(in_word_t w);
			out_word_t o;
			int cnt;
			longint st [3];
			longint dr [3];
			longint org [3];
			longint vec [3];
			longint v1 [4];
			longint v2 [4];
			longint s1, s2, a1, a2, a, r, rmax, rmin, t;
			bit miss;
			cnt = (dim == DIM_TET) ? 3 : 2;
			t = longint'(tol);
			st = '{sx(w.start_x), sx(w.start_y), sx(w.start_z)};
			dr = '{sx(w.dir_x), sx(w.dir_y), sx(w.dir_z)};
			org = '{sx(words[4][63:32]), sx(words[5][31:0]), sx(words[5][63:32])};
			s1 = 0;
			s2 = 0;
			miss = 0;
			rmin = 0;
			rmax = clamp(RANGE_HI * ONE);
			for (int i = 0; i < cnt; i++) vec[i] = clamp(st[i] - org[i]);
			for (int k = 0; k < cnt; k++) begin
				a1 = 0;
				a2 = 0;
				for (int j = 0; j < cnt; j++) begin
					a = coef(k + j * cnt);
					a1 += qmul(a, vec[j]);
					a2 += qmul(a, dr[j]);
				end
				v1[k] = clamp(a1);
				v2[k] = clamp(a2);
				s1 += v1[k];
				s2 += v2[k];
			end
			v1[cnt] = clamp(ONE - s1);
			v2[cnt] = clamp(-s2);
			for (int i = 0; i <= cnt; i++) begin
				if (v2[i] < -t) begin
					r = clamp((-v1[i] * ONE) / v2[i]);
					if (r < rmax) rmax = r;
				end else if (v2[i] > t) begin
					r = clamp((-v1[i] * ONE) / v2[i]);
					if (r > rmin) rmin = r;
				end else if (v1[i] < -t) begin
					miss = 1;
					break;
				end
			end
			o = '0;
			if (!miss && rmax > rmin) begin
				fx_t en [4];
				fx_t ex [4];
				en = '{default: '0};
				ex = '{default: '0};
				for (int i = 0; i <= cnt; i++) begin
					en[i] = fx_t'(clamp(v1[i] + qmul(v2[i], rmin)));
					ex[i] = fx_t'(clamp(v1[i] + qmul(v2[i], rmax)));
				end
				o.hit = 1'b1;
				o.entry_b0 = en[0];
				o.entry_b1 = en[1];
				o.entry_b2 = en[2];
				o.entry_b3 = en[3];
				o.exit_b0 = ex[0];
				o.exit_b1 = ex[1];
				o.exit_b2 = ex[2];
				o.exit_b3 = ex[3];
				o.exit_param = fx_t'(rmax);
			end
			return o;
		endfunction

		function void note_ray(in_word_t w);
			pending.push_back(clip(w));
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$error("%s: expected %h, got %h", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(out_word_t a);
			out_word_t e;
			results++;
			if (pending.size() == 0) begin
				$error("result with no ray outstanding: %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.hit) hits++;
			cmp("hit", 32'(e.hit), 32'(a.hit));
			cmp("entry_b0", e.entry_b0, a.entry_b0);
			cmp("entry_b1", e.entry_b1, a.entry_b1);
			cmp("entry_b2", e.entry_b2, a.entry_b2);
			cmp("entry_b3", e.entry_b3, a.entry_b3);
			cmp("exit_b0", e.exit_b0, a.exit_b0);
			cmp("exit_b1", e.exit_b1, a.exit_b1);
			cmp("exit_b2", e.exit_b2, a.exit_b2);
			cmp("exit_b3", e.exit_b3, a.exit_b3);
			cmp("exit_param", e.exit_param, a.exit_param);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	in_word_t ray = '0;
	logic done;
	out_word_t result;

	clip_scoreboard sb = new();
	int idle_cycles = 0;
	int rays_sent = 0;

	ray_simplex_clip u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .ray(ray), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic reg_write(int idx, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx << ADDR_LSB);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_ray(in_word_t w);
		int gap;
		start <= 1'b1;
		ray <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_ray(w);
		rays_sent++;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic fx_t near_val(int span);
		return fx_t'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic in_word_t rand_ray();
		in_word_t w;
		if ($urandom_range(0, 3) != 0) begin
			w.start_x = near_val(2 * 65536);
			w.start_y = near_val(2 * 65536);
			w.start_z = near_val(2 * 65536);
			w.dir_x = near_val(65536);
			w.dir_y = near_val(65536);
			w.dir_z = near_val(65536);
			if ($urandom_range(0, 7) == 0) w.dir_y = near_val(2);
		end else begin
			w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		end
		return w;
	endfunction

	task automatic load_simplex(logic [31:0] m [9], logic [31:0] o [3]);
		reg_write(0, {m[1], m[0]});
		reg_write(1, {m[3], m[2]});
		reg_write(2, {m[5], m[4]});
		reg_write(3, {m[7], m[6]});
		reg_write(4, {o[0], m[8]});
		reg_write(5, {o[2], o[1]});
	endtask

	task automatic random_rays(int n);
		repeat (n) send_ray(rand_ray());
	endtask

	initial begin
		logic [31:0] m [9];
		logic [31:0] o [3];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: zero matrix, every facet parallel
		send_ray('0);
		send_ray({6{FX_MAX}});
		send_ray({6{FX_MIN}});
		random_rays(60);
		drain();

		// identity tetrahedron, zero tolerance
		m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		o = '{0, 0, 0};
		load_simplex(m, o);
		reg_write(int'(REG_TOL), 64'd0);
		reg_write(int'(REG_DIM), 64'(DIM_TET));
		send_ray({32'h4000, 32'h4000, 32'h4000, 32'h10000, 32'h0, 32'h0});
		send_ray({32'h4000, 32'h4000, 32'h4000, 32'h0, 32'h0, 32'h0});
		send_ray({32'hfffe0000, 32'h4000, 32'h4000, 32'h0, 32'h0, 32'h0});
		send_ray({32'hfffe0000, 32'h4000, 32'h4000, 32'h10000, 32'h0, 32'h0});
		send_ray({32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1});
		send_ray({32'h20000, 32'h20000, 32'h20000, 32'h10000, 32'h10000, 32'h10000});
		send_ray({FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN});
		random_rays(420);
		drain();

		// identity triangle with offset origin and moderate tolerance
		m = '{32'h10000, 0, 0, 32'h10000, 0, 0, 0, 0, 0};
		o = '{32'hffff8000, 32'h8000, 32'h12345678};
		load_simplex(m, o);
		reg_write(int'(REG_TOL), 64'h100);
		reg_write(int'(REG_DIM), 64'd2);
		send_ray({32'h8000, 32'h8000, FX_MAX, 32'h10000, 32'h0, FX_MIN});
		send_ray({32'h0, 32'h10000, 32'h0, 32'h80, 32'h0, 32'h0});
		random_rays(420);
		drain();

		// random tetrahedron, largest tolerance
		foreach (m[i]) m[i] = (i % 4 == 0) ? $urandom_range(32'h8000, 32'h30000) : $urandom;
		o = '{$urandom, $urandom, $urandom};
		load_simplex(m, o);
		reg_write(int'(REG_TOL), 64'h7fffffff);
		reg_write(int'(REG_DIM), 64'(DIM_TET));
		random_rays(300);
		drain();

		// near-identity tetrahedron matrix with small perturbation; dimension codes below two, then tetrahedron
		foreach (m[i]) m[i] = (i % 4 == 0) ? 32'h10000 + $urandom_range(0, 32'h800) :
			32'($urandom_range(0, 32'h400));
		o = '{near_val(32'h4000), near_val(32'h4000), near_val(32'h4000)};
		load_simplex(m, o);
		reg_write(int'(REG_TOL), 64'h10);
		reg_write(int'(REG_DIM), 64'd0);
		random_rays(250);
		drain();
		reg_write(int'(REG_DIM), 64'd1);
		random_rays(200);
		drain();
		reg_write(int'(REG_DIM), 64'(DIM_TET));
		reg_write(int'(REG_TOL), 64'd1);
		random_rays(250);
		drain();

		$display("covered %0d rays over seven register settings, %0d results, %0d hits",
			rays_sent, sb.results, sb.hits);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
